### rtl/ttad_pkg.sv
// ----------------------------------------------------------------------------
// Teletext attribute decoder package
// Shared types, codes and constants for the serial attribute decoder.
// ----------------------------------------------------------------------------
package ttad_pkg;

	localparam int CODE_W   = 7;
	localparam int GLYPH_W  = 9;
	localparam int COLOUR_W = 3;

	localparam logic [CODE_W-1:0]   FIRST_PRINTABLE = 7'h20;
	localparam logic [GLYPH_W-1:0]  SET_SIZE        = 9'd96;
	localparam logic [GLYPH_W-1:0]  GLYPH_SPACE     = '0;
	localparam logic [COLOUR_W-1:0] COLOUR_BLACK    = 3'd0;
	localparam logic [COLOUR_W-1:0] COLOUR_WHITE    = 3'd7;

	// Control codes handled individually.
	localparam logic [4:0] CTL_FLASH      = 5'd8;
	localparam logic [4:0] CTL_STEADY     = 5'd9;
	localparam logic [4:0] CTL_NORMAL_HT  = 5'd12;
	localparam logic [4:0] CTL_DOUBLE_HT  = 5'd13;
	localparam logic [4:0] CTL_CONCEAL    = 5'd24;
	localparam logic [4:0] CTL_CONTIG     = 5'd25;
	localparam logic [4:0] CTL_SEPARATED  = 5'd26;
	localparam logic [4:0] CTL_BLACK_BG   = 5'd27;
	localparam logic [4:0] CTL_NEW_BG     = 5'd29;
	localparam logic [4:0] CTL_HOLD       = 5'd30;
	localparam logic [4:0] CTL_RELEASE    = 5'd31;

	// Upper two bits of a control code that select the colour groups.
	localparam logic [1:0] GRP_ALPHA_COLOUR  = 2'b00;
	localparam logic [1:0] GRP_MOSAIC_COLOUR = 2'b10;

	typedef enum logic [1:0] {
		GSET_ALPHA = 2'd0,
		GSET_CONT  = 2'd1,
		GSET_SEP   = 2'd2
	} glyph_set_t;

	typedef struct packed {
		logic [COLOUR_W-1:0] alpha_colour;
		logic [COLOUR_W-1:0] shown_colour;
		logic [COLOUR_W-1:0] background;
		glyph_set_t          glyph_set;
		logic                conceal_on;
		logic                double_on;
		logic [GLYPH_W-1:0]  held_glyph;
		logic [GLYPH_W-1:0]  last_glyph;
	} attr_state_t;

	typedef struct packed {
		logic [GLYPH_W-1:0]  glyph_index;
		logic [COLOUR_W-1:0] fore_colour;
		logic [COLOUR_W-1:0] back_colour;
		logic                double_high;
	} cell_result_t;

	localparam attr_state_t ROW_RESET_STATE = '{
		alpha_colour: COLOUR_WHITE,
		shown_colour: COLOUR_WHITE,
		background:   COLOUR_BLACK,
		glyph_set:    GSET_ALPHA,
		conceal_on:   1'b0,
		double_on:    1'b0,
		held_glyph:   GLYPH_SPACE,
		last_glyph:   GLYPH_SPACE
	};

endpackage

### rtl/ttad_decode.sv
// ----------------------------------------------------------------------------
// Teletext attribute decode logic
// Applies one character code to the row attributes and forms the cell result.
// ----------------------------------------------------------------------------
module ttad_decode (
	input  logic [ttad_pkg::CODE_W-1:0] char_code,
	input  logic                        row_start,
	input  ttad_pkg::attr_state_t       cur_state,
	output ttad_pkg::attr_state_t       next_state,
	output ttad_pkg::cell_result_t      result
);
	import ttad_pkg::*;

	attr_state_t        st;
	logic [GLYPH_W-1:0] set_base;
	logic [GLYPH_W-1:0] glyph;

	always_comb begin
		st = row_start ? ROW_RESET_STATE : cur_state;

		case (st.glyph_set)
			GSET_CONT: set_base = SET_SIZE;
			GSET_SEP:  set_base = GLYPH_W'(2 * SET_SIZE);
			default:   set_base = '0;
		endcase

		if (char_code < FIRST_PRINTABLE) begin
			if (char_code[4:3] == GRP_ALPHA_COLOUR) begin
				st.alpha_colour = char_code[COLOUR_W-1:0];
				st.shown_colour = char_code[COLOUR_W-1:0];
				st.glyph_set    = GSET_ALPHA;
				st.conceal_on   = 1'b0;
			end else if (char_code[4:3] == GRP_MOSAIC_COLOUR) begin
				st.shown_colour = char_code[COLOUR_W-1:0];
				st.glyph_set    = GSET_CONT;
				st.conceal_on   = 1'b0;
			end else begin
				case (char_code[4:0])
					CTL_FLASH, CTL_STEADY: st.shown_colour = st.alpha_colour;
					CTL_NORMAL_HT:         st.double_on    = 1'b0;
					CTL_DOUBLE_HT:         st.double_on    = 1'b1;
					CTL_CONCEAL:           st.conceal_on   = 1'b1;
					CTL_CONTIG:            st.glyph_set    = GSET_CONT;
					CTL_SEPARATED:         st.glyph_set    = GSET_SEP;
					CTL_BLACK_BG:          st.background   = COLOUR_BLACK;
					CTL_NEW_BG:            st.background   = st.alpha_colour;
					CTL_HOLD:              st.held_glyph   = st.last_glyph;
					CTL_RELEASE:           st.held_glyph   = GLYPH_SPACE;
					default:               ;
				endcase
			end
			glyph = st.held_glyph;
		end else begin
			glyph = set_base + GLYPH_W'(char_code - FIRST_PRINTABLE);
		end

		if (st.conceal_on) begin
			glyph = GLYPH_SPACE;
		end
		st.last_glyph = glyph;

		next_state         = st;
		result.glyph_index = glyph;
		result.fore_colour = st.shown_colour;
		result.back_colour = st.background;
		result.double_high = st.double_on;
	end

endmodule

### rtl/teletext_attribute_decoder_core.sv
// ----------------------------------------------------------------------------
// Teletext attribute decoder core
// Serial attribute decoder: one character code in, one coloured glyph out.
// ----------------------------------------------------------------------------
// Input channel: char_code and row_start, qualified by in_valid; the block
// holds off the sender with in_stall. Output channel: glyph_index,
// fore_colour, back_colour and double_high, qualified by out_valid; the
// receiver holds them with out_stall.
// An accepted code is captured in an input register and is decoded from
// there into the result register when the output advances, after which
// out_valid offers the result to the receiver.
// One code is taken every cycle while the output flows;
// the row attribute register is updated as each code passes decode.
// Assert row_start with the first code of each display row.
// Reset clears both pipeline stages and restores white alpha on black.
// When the receiver stalls, the result is held; one more code is taken into
// the input register, after which in_stall follows out_stall.
// ----------------------------------------------------------------------------
module teletext_attribute_decoder_core (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic [ttad_pkg::CODE_W-1:0]   char_code,
	input  logic                          row_start,
	input  logic                          in_valid,
	output logic                          in_stall,
	output logic [ttad_pkg::GLYPH_W-1:0]  glyph_index,
	output logic [ttad_pkg::COLOUR_W-1:0] fore_colour,
	output logic [ttad_pkg::COLOUR_W-1:0] back_colour,
	output logic                          double_high,
	output logic                          out_valid,
	input  logic                          out_stall
);
	import ttad_pkg::*;

	logic                char_valid_s1;
	logic [CODE_W-1:0]   char_code_s1;
	logic                row_start_s1;
	attr_state_t         state_q;
	attr_state_t         state_next;
	cell_result_t        result_next;
	cell_result_t        result_q;
	logic                out_valid_q;
	logic                advance;
	logic                in_take;

	assign advance  = !out_valid_q || !out_stall;
	assign in_stall = char_valid_s1 && !advance;
	assign in_take  = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			char_valid_s1 <= 1'b0;
		end else if (!char_valid_s1 || advance) begin
			char_valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_take) begin
			char_code_s1 <= char_code;
			row_start_s1 <= row_start;
		end
	end

	ttad_decode u_decode (
		.char_code  (char_code_s1),
		.row_start  (row_start_s1),
		.cur_state  (state_q),
		.next_state (state_next),
		.result     (result_next)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ROW_RESET_STATE;
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= char_valid_s1;
			if (char_valid_s1) begin
				state_q <= state_next;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (advance && char_valid_s1) begin
			result_q <= result_next;
		end
	end

	assign out_valid   = out_valid_q;
	assign glyph_index = result_q.glyph_index;
	assign fore_colour = result_q.fore_colour;
	assign back_colour = result_q.back_colour;
	assign double_high = result_q.double_high;

endmodule

### rtl/ttad_checker.sv
// ----------------------------------------------------------------------------
// Teletext attribute decoder checker
// Port-level assertions on the decoder core, attached by bind.
// ----------------------------------------------------------------------------
module ttad_checker (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          in_valid,
	input logic                          in_stall,
	input logic [ttad_pkg::GLYPH_W-1:0]  glyph_index,
	input logic [ttad_pkg::COLOUR_W-1:0] fore_colour,
	input logic [ttad_pkg::COLOUR_W-1:0] back_colour,
	input logic                          double_high,
	input logic                          out_valid,
	input logic                          out_stall
);
	import ttad_pkg::*;

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(glyph_index) &&
			$stable(fore_colour) && $stable(back_colour) && $stable(double_high))
		else $error("Stalled output transaction changed.");

	a_glyph_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> glyph_index < GLYPH_W'(3 * SET_SIZE))
		else $error("Glyph index beyond the third glyph set.");

	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> out_valid && out_stall)
		else $error("Input stalled while the output was free.");

	a_idle_flow: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !out_valid |-> !in_stall)
		else $error("Input stalled with an empty output register.");

endmodule

bind teletext_attribute_decoder_core ttad_checker u_ttad_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.in_valid    (in_valid),
	.in_stall    (in_stall),
	.glyph_index (glyph_index),
	.fore_colour (fore_colour),
	.back_colour (back_colour),
	.double_high (double_high),
	.out_valid   (out_valid),
	.out_stall   (out_stall)
);
